// ----- hdl/ple_pkg.sv -----
// Package for the positional list engine: sizes, operation and status codes,
// and the word types of the input, output and controller command paths.
// No dependencies.
`default_nettype none

package ple_pkg;

  // Number of entries the list can hold.
  localparam int unsigned Capacity  = 16;
  localparam int unsigned ValW      = 32;
  localparam int unsigned PosW      = 5;
  localparam int unsigned EntryCntW = 5;
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned IdxW      = (Capacity > 1) ? $clog2(Capacity) : 1;
  // Compare width wide enough for count + 1 and for any position.
  localparam int unsigned CmpW      = ((CntW > PosW) ? CntW : PosW) + 1;

  localparam logic signed [ValW-1:0] NoneValue = -32'sd1;

  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_INSERT      = 2'd1,
    OP_REMOVE_LAST = 2'd2,
    OP_REMOVE_AT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                    op;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] removed_value;
    status_e                status;
    logic [EntryCntW-1:0]   entry_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/ple_ctrl.sv -----
// Controller of the positional list engine: two-state sequencer and the
// output valid flag. Depends on ple_pkg.
`default_nettype none

module ple_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ple_pkg::ctrl_cmd_t     cmd_o
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The result register is free when empty or being drained this cycle.
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = fire;

endmodule

`default_nettype wire

// ----- hdl/ple_datapath.sv -----
// Datapath of the positional list engine: request register, the row of
// list cells with their shift logic, the count and the result register.
// Depends on ple_pkg.
`default_nettype none

module ple_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ple_pkg::ctrl_cmd_t  cmd_i,
  input  wire ple_pkg::in_word_t   in_word_i,
  output ple_pkg::out_word_t       out_word_o
);
  import ple_pkg::*;

  in_word_t               req_q;
  out_word_t              out_q;
  logic [CntW-1:0]        count_q, count_d;
  logic signed [ValW-1:0] entries_q [Capacity];
  logic signed [ValW-1:0] from_lo   [Capacity];
  logic signed [ValW-1:0] from_hi   [Capacity];

  logic [CmpW-1:0] cnt_ext, pos_ext, idx_ext;
  logic [IdxW-1:0] idx;
  logic            full, do_ins, do_rem;
  status_e         status;

  assign cnt_ext = CmpW'(count_q);
  assign pos_ext = CmpW'(req_q.position);
  assign full    = (cnt_ext >= CmpW'(Capacity));

  always_comb begin
    status  = ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    idx_ext = pos_ext - CmpW'(1);
    case (req_q.op)
      OP_APPEND: begin
        idx_ext = cnt_ext;
        if (full) status = ST_FULL;
        else      do_ins = 1'b1;
      end
      OP_INSERT: begin
        // The position check takes priority over the full check.
        if (pos_ext == '0 || pos_ext > cnt_ext + CmpW'(1)) status = ST_RANGE;
        else if (full)                                     status = ST_FULL;
        else                                               do_ins = 1'b1;
      end
      OP_REMOVE_LAST: begin
        idx_ext = cnt_ext - CmpW'(1);
        if (cnt_ext == '0) status = ST_EMPTY;
        else               do_rem = 1'b1;
      end
      OP_REMOVE_AT: begin
        if (cnt_ext == '0)                              status = ST_EMPTY;
        else if (pos_ext == '0 || pos_ext > cnt_ext)    status = ST_RANGE;
        else                                            do_rem = 1'b1;
      end
      default: status = ST_OK;
    endcase
  end

  assign idx = idx_ext[IdxW-1:0];

  always_comb begin
    count_d = count_q;
    if (do_ins)      count_d = count_q + CntW'(1);
    else if (do_rem) count_d = count_q - CntW'(1);
  end

  // Each cell compares its own index with the target and takes the new word,
  // its lower neighbor (insert) or its upper neighbor (remove), or keeps its own.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    localparam logic [CmpW-1:0] CellIdx = CmpW'(i);

    if (i == 0) begin : g_lo_edge
      assign from_lo[i] = entries_q[i];
    end else begin : g_lo
      assign from_lo[i] = entries_q[i-1];
    end

    if (i == Capacity - 1) begin : g_hi_edge
      assign from_hi[i] = entries_q[i];
    end else begin : g_hi
      assign from_hi[i] = entries_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        if (do_ins) begin
          if (CellIdx == idx_ext)     entries_q[i] <= req_q.value;
          else if (CellIdx > idx_ext) entries_q[i] <= from_lo[i];
        end else if (do_rem && CellIdx >= idx_ext) begin
          entries_q[i] <= from_hi[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_word_i;
    if (cmd_i.exec) begin
      out_q.removed_value <= do_rem ? entries_q[idx] : NoneValue;
      out_q.status        <= status;
      out_q.entry_count   <= EntryCntW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
//
// Ordered list of up to 16 signed 32-bit words, positions counted from 1.
// Each input word carries an operation (append, insert at position, remove
// last, remove at position); each produces exactly one output word with the
// removed value (-1 unless a remove succeeds), a status code and the entry
// count after the operation. An operation first registers the request, then
// every list cell compares its index with the target and shifts in parallel;
// that step waits while a result is still held on the output, and the block
// takes no new word until the current one is done. The result register lets
// the next word be taken while a result is still waiting on the output.
`default_nettype none

module positional_list_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ple_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ple_pkg::out_word_t      out_word_o
);
  import ple_pkg::*;

  ctrl_cmd_t cmd;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ple_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ----- hdl/ple_checker.sv -----
// Port-level checker for the positional list engine and its bind statement.
// Depends on ple_pkg and positional_list_engine.
`default_nettype none

module ple_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire ple_pkg::out_word_t out_word_o
);
  import ple_pkg::*;

  // A result word waiting on the output stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a request is in work");

  // Failed operations report the none value.
  a_error_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |-> out_word_o.removed_value == NoneValue)
    else $error("error result without the none value");

  // An empty-list error only happens with no entries held.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_EMPTY |-> out_word_o.entry_count == '0)
    else $error("empty status with entries held");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.entry_count <= EntryCntW'(Capacity))
    else $error("entry count beyond capacity");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
